@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the local clock and reset
`define ASSERT_CLK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// expression must never hold
`define ASSERT_NEVER(lbl, expr) \
   `ASSERT_CLK(lbl, !(expr))

`endif

@@ hdl/ldtw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ldtw_pkg;

   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_WRITE = 3'd1;
   localparam logic [2:0] CMD_READ  = 3'd2;
   localparam logic [2:0] CMD_ON    = 3'd3;
   localparam logic [2:0] CMD_OFF   = 3'd4;
   localparam logic [2:0] CMD_INIT  = 3'd5;

   localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
   localparam logic [2:0] REG_DIGIT0     = 3'd1;
   localparam logic [2:0] REG_DIGIT1     = 3'd2;
   localparam logic [2:0] REG_DIGIT2     = 3'd3;
   localparam logic [2:0] REG_DIGIT3     = 3'd4;
   localparam logic [2:0] REG_TIMEOUT    = 3'd5;

   localparam logic [7:0] ADDR_READ_KEY = 8'h49;
   localparam logic [7:0] ADDR_CONTROL  = 8'h48;
   localparam logic [7:0] DATA_INIT     = 8'h40;
   localparam logic [7:0] DATA_ON_BIT   = 8'h01;

   localparam logic [2:0] RST_BRIGHTNESS = 3'd6;
   localparam logic [7:0] RST_DIGIT0     = 8'h68;
   localparam logic [7:0] RST_DIGIT1     = 8'h6A;
   localparam logic [7:0] RST_DIGIT2     = 8'h6C;
   localparam logic [7:0] RST_DIGIT3     = 8'h6E;
   localparam logic [7:0] RST_TIMEOUT    = 8'd200;

   typedef struct packed {
      logic [2:0]      brightness;
      logic [3:0][7:0] digit_addr;
      logic [7:0]      ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic [7:0] key_code;
      logic       key_valid;
      logic       busy_res;
      logic       retry;
   } res_type;

endpackage
`default_nettype wire

@@ hdl/ldtw_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface ldtw_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [7:0] target;
   logic [7:0] wdata;
   logic       sda_in;

   modport source (output valid, cmd, target, wdata, sda_in, input ready);
   modport sink   (input valid, cmd, target, wdata, sda_in, output ready);
endinterface
`default_nettype wire

@@ hdl/ldtw_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface ldtw_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl;
   logic       sda_out;
   logic [7:0] key_code;
   logic       key_valid;
   logic       busy_res;
   logic       retry;

   modport source (output valid, scl, sda_out, key_code, key_valid, busy_res, retry,
                   input ready);
   modport sink   (input valid, scl, sda_out, key_code, key_valid, busy_res, retry,
                   output ready);
endinterface
`default_nettype wire

@@ hdl/ldtw_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ldtw_seq
   import ldtw_pkg::*;
#(
   parameter int DIGITS = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [2:0] cmd,
   input  wire logic [7:0] target,
   input  wire logic [7:0] wdata,
   input  wire logic       sda_in,
   input  wire cfg_type    cfg,
   output res_type         res
);

   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_START0  = 5'd1;
   localparam logic [4:0] PH_START1  = 5'd2;
   localparam logic [4:0] PH_START2  = 5'd3;
   localparam logic [4:0] PH_AB_LOW  = 5'd4;
   localparam logic [4:0] PH_AB_HIGH = 5'd5;
   localparam logic [4:0] PH_AK_WAIT = 5'd6;
   localparam logic [4:0] PH_AK_HIGH = 5'd7;
   localparam logic [4:0] PH_AK_LOW  = 5'd8;
   localparam logic [4:0] PH_DB_LOW  = 5'd9;
   localparam logic [4:0] PH_DB_HIGH = 5'd10;
   localparam logic [4:0] PH_DK_WAIT = 5'd11;
   localparam logic [4:0] PH_DK_HIGH = 5'd12;
   localparam logic [4:0] PH_DK_LOW  = 5'd13;
   localparam logic [4:0] PH_RD_LOW  = 5'd14;
   localparam logic [4:0] PH_RD_HIGH = 5'd15;
   localparam logic [4:0] PH_STOP0   = 5'd16;
   localparam logic [4:0] PH_STOP1   = 5'd17;
   localparam logic [4:0] PH_STOP2   = 5'd18;

   localparam logic [2:0] LAST_STEP = 3'(DIGITS);

   logic [4:0] phase_ff, phase_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] wait_ff, wait_in;
   logic       late_ff, late_in;
   logic [2:0] job_ff, job_in;
   logic [2:0] init_ff, init_in;
   logic [7:0] key_ff, key_in;

   function automatic logic [7:0] map_addr(input logic [7:0] a, input cfg_type c);
      map_addr = (a < 8'd4) ? c.digit_addr[a[1:0]] : a;
   endfunction

   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      addr_in  = addr_ff;
      data_in  = data_ff;
      wait_in  = wait_ff;
      late_in  = late_ff;
      job_in   = job_ff;
      init_in  = init_ff;
      key_in   = key_ff;
      res.scl       = 1'b1;
      res.sda_out   = 1'b1;
      res.key_valid = 1'b0;
      res.retry     = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (cmd inside {[CMD_WRITE:CMD_INIT]}) begin
               job_in  = cmd;
               init_in = 3'd0;
               if (cmd == CMD_WRITE) begin
                  addr_in = map_addr(target, cfg);
                  data_in = wdata;
               end else if (cmd == CMD_READ) begin
                  addr_in = ADDR_READ_KEY;
                  data_in = 8'd0;
               end else if (cmd == CMD_OFF) begin
                  addr_in = ADDR_CONTROL;
                  data_in = 8'd0;
               end else begin
                  addr_in = ADDR_CONTROL;
                  data_in = {1'b0, cfg.brightness, 4'd0} | DATA_ON_BIT;
               end
               phase_in = PH_START1;
            end
         end
         PH_START0: phase_in = PH_START1;
         PH_START1: begin
            res.sda_out = 1'b0;
            phase_in    = PH_START2;
         end
         PH_START2: begin
            res.scl     = 1'b0;
            res.sda_out = 1'b0;
            shift_in    = addr_ff;
            bit_in      = 4'd0;
            phase_in    = PH_AB_LOW;
         end
         PH_AB_LOW, PH_DB_LOW: begin
            res.scl     = 1'b0;
            res.sda_out = shift_ff[7];
            phase_in    = phase_ff + 5'd1;
         end
         PH_AB_HIGH, PH_DB_HIGH: begin
            // data line holds the bit set up in the low half
            res.sda_out = shift_ff[7];
            shift_in    = {shift_ff[6:0], 1'b0};
            bit_in      = bit_ff + 4'd1;
            if (bit_in >= 4'd8) begin
               wait_in  = 8'd0;
               late_in  = 1'b0;
               phase_in = phase_ff + 5'd1;
            end else begin
               phase_in = phase_ff - 5'd1;
            end
         end
         PH_AK_WAIT, PH_DK_WAIT: begin
            res.scl = 1'b0;
            wait_in = (wait_ff != 8'hFF) ? wait_ff + 8'd1 : wait_ff;
            if (wait_in > cfg.ack_timeout) late_in = 1'b1;
            if (!sda_in) phase_in = phase_ff + 5'd1;
         end
         PH_AK_HIGH, PH_DK_HIGH: phase_in = phase_ff + 5'd1;
         PH_AK_LOW: begin
            res.scl = 1'b0;
            bit_in  = 4'd0;
            if (late_ff) begin
               res.retry = 1'b1;
               bit_in    = bit_ff;
               phase_in  = PH_START0;
            end else if (job_ff == CMD_READ) begin
               shift_in = 8'd0;
               phase_in = PH_RD_LOW;
            end else begin
               shift_in = data_ff;
               phase_in = PH_DB_LOW;
            end
         end
         PH_DK_LOW: begin
            res.scl  = 1'b0;
            phase_in = PH_STOP0;
         end
         PH_RD_LOW: begin
            res.scl  = 1'b0;
            phase_in = PH_RD_HIGH;
         end
         PH_RD_HIGH: begin
            shift_in = {shift_ff[6:0], sda_in};
            bit_in   = bit_ff + 4'd1;
            phase_in = (bit_in >= 4'd8) ? PH_STOP0 : PH_RD_LOW;
         end
         PH_STOP0: begin
            res.scl     = 1'b0;
            res.sda_out = 1'b0;
            phase_in    = PH_STOP1;
         end
         PH_STOP1: begin
            res.sda_out = 1'b0;
            phase_in    = PH_STOP2;
         end
         PH_STOP2: begin
            if (job_ff == CMD_READ) begin
               key_in        = shift_ff;
               res.key_valid = 1'b1;
            end
            if (job_ff == CMD_INIT && init_ff < LAST_STEP) begin
               addr_in  = map_addr(cfg.digit_addr[init_ff[1:0]], cfg);
               data_in  = DATA_INIT;
               init_in  = init_ff + 3'd1;
               phase_in = PH_START0;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      res.key_code = key_in;
      res.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         addr_ff  <= 8'd0;
         data_ff  <= 8'd0;
         wait_ff  <= 8'd0;
         late_ff  <= 1'b0;
         job_ff   <= CMD_TICK;
         init_ff  <= 3'd0;
         key_ff   <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         addr_ff  <= addr_in;
         data_ff  <= data_in;
         wait_ff  <= wait_in;
         late_ff  <= late_in;
         job_ff   <= job_in;
         init_ff  <= init_in;
         key_ff   <= key_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/led_driver_two_wire_master.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Two-wire command master for an LED and key driver chip.
// req_port: one word per bus tick with the sampled SDA level and an optional
//   command (write, key read, display on/off, init). Commands arriving while a
//   transaction runs are dropped.
// rsp_port: exactly one word per request word: SCL level, SDA drive, last key
//   code, key valid pulse, busy and retry flags for that tick.
// csr_*: register writes (brightness, four digit addresses, ack timeout),
//   to be issued only while no word is in flight.
// The response word is registered and appears in the cycle after its request is taken.
// Throughput: one word per cycle while the receiver keeps rsp_port.ready high; the
//   sequencer state advances once per word through a single combinational next-state block.
// A single response register separates the channels: req_port.ready is high
//   while that register is empty or being drained, so a stalled receiver
//   stalls the request side after one word.
// Reset (synchronous): sequencer idle, key code zero, registers at defaults,
//   response register empty.
module led_driver_two_wire_master
   import ldtw_pkg::*;
#(
   parameter int DIGITS = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   ldtw_req_if.sink        req_port,
   ldtw_rsp_if.source      rsp_port,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

`include "assert_macros.svh"

   cfg_type cfg_ff;
   res_type rsp_ff;
   res_type res;
   logic    rsp_valid_ff;
   logic    req_fire;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign req_fire       = req_port.valid && req_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness    <= RST_BRIGHTNESS;
         cfg_ff.digit_addr[0] <= RST_DIGIT0;
         cfg_ff.digit_addr[1] <= RST_DIGIT1;
         cfg_ff.digit_addr[2] <= RST_DIGIT2;
         cfg_ff.digit_addr[3] <= RST_DIGIT3;
         cfg_ff.ack_timeout   <= RST_TIMEOUT;
      end else if (csr_we) begin
         case (csr_index)
            REG_BRIGHTNESS: cfg_ff.brightness    <= csr_wdata[2:0];
            REG_DIGIT0:     cfg_ff.digit_addr[0] <= csr_wdata;
            REG_DIGIT1:     cfg_ff.digit_addr[1] <= csr_wdata;
            REG_DIGIT2:     cfg_ff.digit_addr[2] <= csr_wdata;
            REG_DIGIT3:     cfg_ff.digit_addr[3] <= csr_wdata;
            REG_TIMEOUT:    cfg_ff.ack_timeout   <= csr_wdata;
            default: ;
         endcase
      end
   end

   ldtw_seq #(
      .DIGITS(DIGITS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (req_fire),
      .cmd    (req_port.cmd),
      .target (req_port.target),
      .wdata  (req_port.wdata),
      .sda_in (req_port.sda_in),
      .cfg    (cfg_ff),
      .res    (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) rsp_ff <= res;
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.scl       = rsp_ff.scl;
   assign rsp_port.sda_out   = rsp_ff.sda_out;
   assign rsp_port.key_code  = rsp_ff.key_code;
   assign rsp_port.key_valid = rsp_ff.key_valid;
   assign rsp_port.busy_res  = rsp_ff.busy_res;
   assign rsp_port.retry     = rsp_ff.retry;

   `ASSERT_CLK(a_fire_gives_word, req_fire |=> rsp_valid_ff)
   `ASSERT_NEVER(a_key_while_busy, rsp_valid_ff && rsp_ff.key_valid && rsp_ff.busy_res)
   `ASSERT_NEVER(a_retry_when_idle, rsp_valid_ff && rsp_ff.retry && !rsp_ff.busy_res)

endmodule
`default_nettype wire

@@ sim/tb_led_driver_two_wire_master.sv @@
`timescale 1ns / 1ps
module tb_led_driver_two_wire_master;
   import ldtw_pkg::*;

   localparam int N_DIGITS = 4;
   localparam logic [2:0] CMD_RSVD6   = 3'd6;
   localparam logic [2:0] CMD_RSVD7   = 3'd7;
   localparam logic [2:0] REG_UNUSED6 = 3'd6;
   localparam logic [2:0] REG_UNUSED7 = 3'd7;

   typedef enum logic [4:0] {
      SQ_IDLE, SQ_START0, SQ_START1, SQ_START2, SQ_AB_LOW, SQ_AB_HIGH, SQ_AK_WAIT,
      SQ_AK_HIGH, SQ_AK_LOW, SQ_DB_LOW, SQ_DB_HIGH, SQ_DK_WAIT, SQ_DK_HIGH, SQ_DK_LOW,
      SQ_RD_LOW, SQ_RD_HIGH, SQ_STOP0, SQ_STOP1, SQ_STOP2
   } sq_phase_type;

   // one command and how the bus slave answers it
   typedef struct {
      logic [2:0] cmd;
      logic [7:0] target;
      logic [7:0] wdata;
      int         ack_delay;
      int         late_acks;
      logic [7:0] key;
      bit         noisy;
      bit         typed;
      logic       exp_busy;
   } job_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [7:0] csr_wdata;

   ldtw_req_if req_bus ();
   ldtw_rsp_if rsp_bus ();

   led_driver_two_wire_master #(.DIGITS(N_DIGITS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   int unsigned cyc = 0;
   always @(posedge clock) cyc <= cyc + 1;

   // sequencer model state and register copy
   logic [2:0]   bright_m;
   logic [7:0]   dig_m [4];
   logic [7:0]   tmo_m;
   sq_phase_type sq_phase;
   logic [3:0]   sq_bits;
   logic [7:0]   sq_shift, sq_addr, sq_data, sq_wait, key_m;
   logic [2:0]   sq_job, sq_init;
   logic         sq_late, sq_scl, sq_sda;

   res_type bus_expect [$];
   int      words_sent = 0;
   int      rsp_seen = 0;
   int      bad_words = 0;

   function automatic int pause_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] map_target(input logic [7:0] a);
      return (a < 8'd4) ? dig_m[a[1:0]] : a;
   endfunction

   task automatic reset_model();
      bright_m = RST_BRIGHTNESS;
      dig_m[0] = RST_DIGIT0;
      dig_m[1] = RST_DIGIT1;
      dig_m[2] = RST_DIGIT2;
      dig_m[3] = RST_DIGIT3;
      tmo_m    = RST_TIMEOUT;
      sq_phase = SQ_IDLE;
      sq_bits  = '0;
      sq_shift = '0;
      sq_addr  = '0;
      sq_data  = '0;
      sq_wait  = '0;
      key_m    = '0;
      sq_job   = '0;
      sq_init  = '0;
      sq_late  = 1'b0;
      sq_scl   = 1'b1;
      sq_sda   = 1'b1;
   endtask

   function automatic res_type seq_step(input logic [2:0] c, input logic [7:0] t,
                                        input logic [7:0] w, input logic s);
      res_type r;
      logic    kv;
      logic    rt;
      kv = 1'b0;
      rt = 1'b0;
      case (sq_phase)
         SQ_IDLE: begin
            sq_scl = 1'b1;
            sq_sda = 1'b1;
            if (c >= CMD_WRITE && c <= CMD_INIT) begin
               sq_job  = c;
               sq_init = '0;
               case (c)
                  CMD_WRITE: begin
                     sq_addr = map_target(t);
                     sq_data = w;
                  end
                  CMD_READ: begin
                     sq_addr = ADDR_READ_KEY;
                     sq_data = '0;
                  end
                  CMD_OFF: begin
                     sq_addr = ADDR_CONTROL;
                     sq_data = '0;
                  end
                  default: begin
                     sq_addr = ADDR_CONTROL;
                     sq_data = {1'b0, bright_m, 4'b0000} | DATA_ON_BIT;
                  end
               endcase
               sq_phase = SQ_START1;
            end
         end
         SQ_START0: begin
            sq_scl = 1'b1;
            sq_sda = 1'b1;
            sq_phase = SQ_START1;
         end
         SQ_START1: begin
            sq_scl = 1'b1;
            sq_sda = 1'b0;
            sq_phase = SQ_START2;
         end
         SQ_START2: begin
            sq_scl = 1'b0;
            sq_sda = 1'b0;
            sq_shift = sq_addr;
            sq_bits = '0;
            sq_phase = SQ_AB_LOW;
         end
         SQ_AB_LOW, SQ_DB_LOW: begin
            sq_scl = 1'b0;
            sq_sda = sq_shift[7];
            sq_phase = (sq_phase == SQ_AB_LOW) ? SQ_AB_HIGH : SQ_DB_HIGH;
         end
         SQ_AB_HIGH, SQ_DB_HIGH: begin
            sq_scl = 1'b1;
            sq_shift = sq_shift << 1;
            sq_bits = sq_bits + 4'd1;
            if (sq_bits >= 4'd8) begin
               sq_wait = '0;
               sq_late = 1'b0;
               sq_phase = (sq_phase == SQ_AB_HIGH) ? SQ_AK_WAIT : SQ_DK_WAIT;
            end else begin
               sq_phase = (sq_phase == SQ_AB_HIGH) ? SQ_AB_LOW : SQ_DB_LOW;
            end
         end
         SQ_AK_WAIT, SQ_DK_WAIT: begin
            sq_scl = 1'b0;
            sq_sda = 1'b1;
            if (sq_wait < 8'd255) sq_wait = sq_wait + 8'd1;
            if (sq_wait > tmo_m) sq_late = 1'b1;
            if (!s) sq_phase = (sq_phase == SQ_AK_WAIT) ? SQ_AK_HIGH : SQ_DK_HIGH;
         end
         SQ_AK_HIGH, SQ_DK_HIGH: begin
            sq_scl = 1'b1;
            sq_sda = 1'b1;
            sq_phase = (sq_phase == SQ_AK_HIGH) ? SQ_AK_LOW : SQ_DK_LOW;
         end
         SQ_AK_LOW: begin
            sq_scl = 1'b0;
            sq_sda = 1'b1;
            sq_bits = '0;
            if (sq_late) begin
               rt = 1'b1;
               sq_phase = SQ_START0;
            end else if (sq_job == CMD_READ) begin
               sq_shift = '0;
               sq_phase = SQ_RD_LOW;
            end else begin
               sq_shift = sq_data;
               sq_phase = SQ_DB_LOW;
            end
         end
         SQ_DK_LOW: begin
            sq_scl = 1'b0;
            sq_sda = 1'b1;
            sq_phase = SQ_STOP0;
         end
         SQ_RD_LOW: begin
            sq_scl = 1'b0;
            sq_sda = 1'b1;
            sq_phase = SQ_RD_HIGH;
         end
         SQ_RD_HIGH: begin
            sq_scl = 1'b1;
            sq_sda = 1'b1;
            sq_shift = {sq_shift[6:0], s};
            sq_bits = sq_bits + 4'd1;
            sq_phase = (sq_bits >= 4'd8) ? SQ_STOP0 : SQ_RD_LOW;
         end
         SQ_STOP0: begin
            sq_scl = 1'b0;
            sq_sda = 1'b0;
            sq_phase = SQ_STOP1;
         end
         SQ_STOP1: begin
            sq_scl = 1'b1;
            sq_sda = 1'b0;
            sq_phase = SQ_STOP2;
         end
         SQ_STOP2: begin
            sq_scl = 1'b1;
            sq_sda = 1'b1;
            if (sq_job == CMD_READ) begin
               key_m = sq_shift;
               kv = 1'b1;
            end
            if (sq_job == CMD_INIT && sq_init < N_DIGITS) begin
               sq_addr = map_target(dig_m[sq_init[1:0]]);
               sq_data = DATA_INIT;
               sq_init = sq_init + 3'd1;
               sq_phase = SQ_START0;
            end else begin
               sq_phase = SQ_IDLE;
            end
         end
         default: begin
            sq_scl = 1'b1;
            sq_sda = 1'b1;
            sq_phase = SQ_IDLE;
         end
      endcase
      r.scl       = sq_scl;
      r.sda_out   = sq_sda;
      r.key_code  = key_m;
      r.key_valid = kv;
      r.busy_res  = (sq_phase != SQ_IDLE);
      r.retry     = rt;
      return r;
   endfunction

   task automatic send_word(input logic [2:0] c, input logic [7:0] t, input logic [7:0] w,
                            input logic s, input bit typed, input res_type want);
      int      gap;
      res_type model_res;
      if ((cyc % 600) >= 150 && $urandom_range(0, 99) < 15) begin
         gap = pause_len();
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.cmd    <= c;
      req_bus.target <= t;
      req_bus.wdata  <= w;
      req_bus.sda_in <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
      model_res = seq_step(c, t, w, s);
      bus_expect.push_back(typed ? want : model_res);
   endtask

   // issue one command, then tick until the sequencer is idle again,
   // acting as the slave on the data line
   task automatic run_job(input job_type j);
      res_type    accept_res;
      logic [2:0] c;
      logic       s;
      bit         in_wait;
      int         hold;
      int         late_left;
      accept_res = {1'b1, 1'b1, 8'h00, 1'b0, j.exp_busy, 1'b0};
      in_wait = 1'b0;
      hold = 0;
      late_left = j.late_acks;
      send_word(j.cmd, j.target, j.wdata, 1'($urandom_range(0, 1)), j.typed, accept_res);
      while (sq_phase != SQ_IDLE) begin
         c = CMD_TICK;
         if (j.noisy && $urandom_range(0, 3) == 0) c = 3'($urandom_range(1, 7));
         if (sq_phase == SQ_AK_WAIT || sq_phase == SQ_DK_WAIT) begin
            if (!in_wait) begin
               in_wait = 1'b1;
               if (late_left > 0) begin
                  hold = int'(tmo_m) + $urandom_range(0, 60);
                  late_left--;
               end else begin
                  hold = j.ack_delay;
               end
            end
            s = (hold != 0);
            if (hold > 0) hold--;
         end else begin
            in_wait = 1'b0;
            if (sq_phase == SQ_RD_HIGH) s = j.key[3'd7 - sq_bits[2:0]];
            else s = 1'($urandom_range(0, 1));
         end
         send_word(c, 8'($urandom), 8'($urandom), s, 1'b0, '0);
      end
   endtask

   function automatic job_type row(input logic [2:0] c, input logic [7:0] t,
                                   input logic [7:0] w, input int dly, input int late,
                                   input logic [7:0] key, input bit noisy, input bit typed,
                                   input logic busy);
      job_type j;
      j.cmd = c;
      j.target = t;
      j.wdata = w;
      j.ack_delay = dly;
      j.late_acks = late;
      j.key = key;
      j.noisy = noisy;
      j.typed = typed;
      j.exp_busy = busy;
      return j;
   endfunction

   task automatic random_phase(input int words);
      int      stop_at;
      int      pick;
      bit      first_job;
      job_type j;
      stop_at = words_sent + words;
      first_job = 1'b1;
      while (words_sent < stop_at) begin
         repeat ($urandom_range(0, 3)) begin
            pick = $urandom_range(0, 9);
            send_word((pick == 0) ? CMD_RSVD6 : (pick == 1) ? CMD_RSVD7 : CMD_TICK,
                      8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
         end
         pick = $urandom_range(0, 99);
         j.cmd = (pick < 45) ? CMD_WRITE : (pick < 70) ? CMD_READ : (pick < 80) ? CMD_ON :
                 (pick < 90) ? CMD_OFF : (pick < 95) ? CMD_INIT : CMD_TICK;
         j.target = ($urandom_range(0, 9) < 3) ? 8'($urandom_range(0, 3)) : 8'($urandom);
         j.wdata = 8'($urandom);
         j.ack_delay = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 4);
         // late answers only where the timeout keeps them short
         j.late_acks = (tmo_m < 8'd40 && (first_job || $urandom_range(0, 99) < 25)) ? 1 : 0;
         j.key = 8'($urandom);
         j.noisy = ($urandom_range(0, 9) < 3);
         j.typed = 1'b0;
         j.exp_busy = 1'b0;
         first_job = 1'b0;
         run_job(j);
      end
   endtask

   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (bus_expect.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic reg_write(input logic [2:0] idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_BRIGHTNESS: bright_m = value[2:0];
         REG_DIGIT0:     dig_m[0] = value;
         REG_DIGIT1:     dig_m[1] = value;
         REG_DIGIT2:     dig_m[2] = value;
         REG_DIGIT3:     dig_m[3] = value;
         REG_TIMEOUT:    tmo_m = value;
         default: ;
      endcase
   endtask

   task automatic load_regs(input logic [2:0] b, input logic [7:0] d0, input logic [7:0] d1,
                            input logic [7:0] d2, input logic [7:0] d3,
                            input logic [7:0] tmo);
      reg_write(REG_BRIGHTNESS, {5'($urandom), b});
      reg_write(REG_DIGIT0, d0);
      reg_write(REG_DIGIT1, d1);
      reg_write(REG_DIGIT2, d2);
      reg_write(REG_DIGIT3, d3);
      reg_write(REG_TIMEOUT, tmo);
      reg_write(REG_UNUSED6, 8'($urandom));
      reg_write(REG_UNUSED7, 8'($urandom));
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      job_type dir_jobs [$];
      int      k;
      reset_model();
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.cmd    <= CMD_TICK;
      req_bus.target <= '0;
      req_bus.wdata  <= '0;
      req_bus.sda_in <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= REG_BRIGHTNESS;
      csr_wdata      <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // lines released and idle until a command comes; late means wait > timeout
      dir_jobs.push_back(row(CMD_TICK,  8'h00, 8'h00,   0, 0, 8'h00, 0, 1, 1'b0));
      dir_jobs.push_back(row(CMD_RSVD6, 8'hFF, 8'hFF,   0, 0, 8'h00, 0, 1, 1'b0));
      dir_jobs.push_back(row(CMD_RSVD7, 8'h00, 8'h00,   0, 0, 8'h00, 0, 1, 1'b0));
      dir_jobs.push_back(row(CMD_WRITE, 8'h00, 8'h00,   0, 0, 8'h00, 0, 1, 1'b1));
      dir_jobs.push_back(row(CMD_WRITE, 8'h03, 8'hFF,   3, 0, 8'h00, 0, 1, 1'b1));
      dir_jobs.push_back(row(CMD_WRITE, 8'h04, 8'hA5,   1, 0, 8'h00, 0, 1, 1'b1));
      dir_jobs.push_back(row(CMD_WRITE, 8'hFF, 8'h5A,   0, 0, 8'h00, 1, 1, 1'b1));
      dir_jobs.push_back(row(CMD_WRITE, 8'h01, 8'h3C, 199, 0, 8'h00, 0, 1, 1'b1));
      dir_jobs.push_back(row(CMD_WRITE, 8'h02, 8'hC3,   0, 1, 8'h00, 0, 1, 1'b1));
      dir_jobs.push_back(row(CMD_READ,  8'h00, 8'h00,   0, 0, 8'hFF, 0, 1, 1'b1));
      dir_jobs.push_back(row(CMD_READ,  8'hFF, 8'hFF,   2, 0, 8'h00, 0, 0, 1'b0));
      dir_jobs.push_back(row(CMD_READ,  8'h12, 8'h34,   0, 0, 8'h96, 1, 0, 1'b0));
      dir_jobs.push_back(row(CMD_ON,    8'h00, 8'h00,   0, 0, 8'h00, 0, 0, 1'b0));
      dir_jobs.push_back(row(CMD_OFF,   8'h00, 8'h00,   1, 0, 8'h00, 0, 0, 1'b0));
      dir_jobs.push_back(row(CMD_INIT,  8'h00, 8'h00,   0, 0, 8'h00, 1, 0, 1'b0));
      dir_jobs.push_back(row(CMD_INIT,  8'h00, 8'h00,   1, 0, 8'h00, 0, 0, 1'b0));
      for (k = 0; k < dir_jobs.size(); k++) run_job(dir_jobs[k]);
      random_phase(60);

      quiesce();
      load_regs(3'd0, 8'd3, 8'd2, 8'd1, 8'd0, 8'd1);
      random_phase(60);

      quiesce();
      load_regs(3'd7, 8'hFF, 8'h00, 8'h80, 8'h04, 8'd255);
      random_phase(60);

      repeat (2) begin
         quiesce();
         load_regs(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom_range(0, 7)),
                   8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)));
         random_phase(60);
      end

      quiesce();
      repeat (16) @(posedge clock);
      if (bad_words == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: random stalls, one long hold-off to back the block up
   initial begin : rsp_drain
      int hold;
      bit pressure_done;
      hold = 0;
      pressure_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (!pressure_done && rsp_seen >= 500) begin
            pressure_done = 1'b1;
            hold = 300;
            rsp_bus.ready <= 1'b0;
         end else if (((cyc + 300) % 600) >= 150 && $urandom_range(0, 99) < 20) begin
            hold = pause_len() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      res_type got;
      res_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.scl, rsp_bus.sda_out, rsp_bus.key_code, rsp_bus.key_valid,
                rsp_bus.busy_res, rsp_bus.retry};
         rsp_seen++;
         if (bus_expect.size() == 0) begin
            bad_words++;
            if (bad_words <= 10)
               $display("word %0d: response word with nothing pending", rsp_seen);
         end else begin
            want = bus_expect.pop_front();
            if (got.scl !== want.scl || got.sda_out !== want.sda_out ||
                got.key_code !== want.key_code || got.key_valid !== want.key_valid ||
                got.busy_res !== want.busy_res || got.retry !== want.retry) begin
               bad_words++;
               if (bad_words <= 10)
                  $display({"word %0d: exp scl=%b sda=%b key=%02h kv=%b busy=%b retry=%b",
                            " / got scl=%b sda=%b key=%02h kv=%b busy=%b retry=%b"},
                           rsp_seen, want.scl, want.sda_out, want.key_code, want.key_valid,
                           want.busy_res, want.retry, got.scl, got.sda_out, got.key_code,
                           got.key_valid, got.busy_res, got.retry);
            end
         end
      end
   end

   initial begin : watchdog
      #(64'd8_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ldtw_pkg.sv
hdl/ldtw_req_if.sv
hdl/ldtw_rsp_if.sv
hdl/ldtw_seq.sv
hdl/led_driver_two_wire_master.sv
sim/tb_led_driver_two_wire_master.sv
